[hw/rtl/u8sd_pkg.sv]
// Shared types and widths for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  // One byte after classification by the front end.
  typedef struct packed {
    logic [LEN_W-1:0] lead_len;   // 1..4, invalid lead counts as 1
    logic             is_ascii;   // byte below 0x80
    logic             cont_ok;    // byte has the form 10xxxxxx
    logic [4:0]       lead_bits;  // payload bits of a multi-byte lead
    logic [5:0]       cont_bits;  // payload bits of a continuation byte
    logic [6:0]       ascii_bits; // low seven bits of the byte
    logic             eos;        // last byte of the string
  } cls_t;

endpackage

[hw/rtl/u8sd_front.sv]
// Front end: accepts raw bytes and classifies them for the sequence engine.
module u8sd_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output u8sd_pkg::cls_t    q_wdata
);
  import u8sd_pkg::*;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  logic [LEN_W-1:0] len;
  logic [4:0]       lead_bits;

  always_comb begin
    len       = LEN_W'(1);
    lead_bits = '0;
    priority if (!in_tdata[7]) begin
      len = LEN_W'(1);
    end else if ((in_tdata & LEAD2_MASK) == LEAD2_CODE) begin
      len       = LEN_W'(2);
      lead_bits = in_tdata[4:0];
    end else if ((in_tdata & LEAD3_MASK) == LEAD3_CODE) begin
      len       = LEN_W'(3);
      lead_bits = {1'b0, in_tdata[3:0]};
    end else if ((in_tdata & LEAD4_MASK) == LEAD4_CODE) begin
      len       = LEN_W'(4);
      lead_bits = {2'b00, in_tdata[2:0]};
    end else begin
      len = LEN_W'(1);
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata.lead_len   = len;
    q_wdata.is_ascii   = !in_tdata[7];
    q_wdata.cont_ok    = (in_tdata & CONT_MASK) == CONT_CODE;
    q_wdata.lead_bits  = lead_bits;
    q_wdata.cont_bits  = in_tdata[5:0];
    q_wdata.ascii_bits = in_tdata[6:0];
    q_wdata.eos        = in_tlast;
  end

endmodule

[hw/rtl/u8sd_fifo.sv]
// Small queue of classified bytes between the front end and the sequence engine.
module u8sd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8sd_pkg::cls_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output u8sd_pkg::cls_t rdata
);
  import u8sd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

endmodule

[hw/rtl/u8sd_back.sv]
// Sequence engine: gathers classified bytes into code points and holds the result register.
module u8sd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_not_empty,
  input  u8sd_pkg::cls_t                     q_rdata,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [u8sd_pkg::CP_W-1:0]          out_code_point,
  output logic [u8sd_pkg::LEN_W-1:0]         out_seq_length,
  output logic                               out_valid_res,
  output logic                               out_is_modifier,
  output logic                               out_last
);
  import u8sd_pkg::*;

  localparam logic [CP_W-1:0] VS15    = CP_W'(21'h0FE0E);
  localparam logic [CP_W-1:0] VS16    = CP_W'(21'h0FE0F);
  localparam logic [CP_W-1:0] SKIN_LO = CP_W'(21'h1F3FB);
  localparam logic [CP_W-1:0] SKIN_HI = CP_W'(21'h1F3FF);

  logic [1:0]       bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0] seq_total_r, seq_total_nxt;
  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic             broken_r, broken_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]  cp_r, cp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ok_r, ok_nxt;
  logic             mod_r, mod_nxt;
  logic             last_r, last_nxt;

  logic             advance;
  logic             emit;
  logic [1:0]       bl_dec;
  logic             brk_upd;
  logic [CP_W-1:0]  pp_upd;
  logic [CP_W-1:0]  emit_cp;
  logic [LEN_W-1:0] emit_len;
  logic             emit_ok;

  // The engine takes a byte whenever the result register is free or being drained.
  assign advance = q_not_empty && (!out_valid_r || out_tready);
  assign q_pop   = advance;

  assign bl_dec  = bytes_left_r - 2'd1;
  assign brk_upd = broken_r || !q_rdata.cont_ok;
  assign pp_upd  = {partial_r[CP_W-7:0], q_rdata.cont_bits};

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seq_total_nxt  = seq_total_r;
    partial_nxt    = partial_r;
    broken_nxt     = broken_r;
    emit           = 1'b0;
    emit_cp        = '0;
    emit_len       = LEN_W'(1);
    emit_ok        = 1'b0;
    if (bytes_left_r == 2'd0) begin
      if (q_rdata.lead_len == LEN_W'(1)) begin
        emit     = 1'b1;
        emit_ok  = q_rdata.is_ascii;
        emit_cp  = q_rdata.is_ascii ? {{(CP_W-7){1'b0}}, q_rdata.ascii_bits} : '0;
        emit_len = LEN_W'(1);
      end else if (q_rdata.eos) begin
        // A multi-byte lead that closes the string is reported as a lone bad byte.
        emit     = 1'b1;
        emit_len = LEN_W'(1);
      end else begin
        partial_nxt    = {{(CP_W-5){1'b0}}, q_rdata.lead_bits};
        seq_total_nxt  = q_rdata.lead_len;
        bytes_left_nxt = 2'(q_rdata.lead_len - LEN_W'(1));
        broken_nxt     = 1'b0;
      end
    end else begin
      if (bl_dec == 2'd0) begin
        emit     = 1'b1;
        emit_ok  = !brk_upd;
        emit_cp  = brk_upd ? '0 : pp_upd;
        emit_len = seq_total_r;
      end else if (q_rdata.eos) begin
        // String ended inside the sequence: report the bytes actually taken.
        emit     = 1'b1;
        emit_len = seq_total_r - {1'b0, bl_dec};
      end else begin
        partial_nxt    = pp_upd;
        bytes_left_nxt = bl_dec;
        broken_nxt     = brk_upd;
      end
    end
    if (emit) begin
      bytes_left_nxt = '0;
      seq_total_nxt  = '0;
      partial_nxt    = '0;
      broken_nxt     = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    cp_nxt        = cp_r;
    len_nxt       = len_r;
    ok_nxt        = ok_r;
    mod_nxt       = mod_r;
    last_nxt      = last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
      cp_nxt        = emit_cp;
      len_nxt       = emit_len;
      ok_nxt        = emit_ok;
      mod_nxt       = emit_ok && (emit_cp == VS15 || emit_cp == VS16 ||
                                  (emit_cp >= SKIN_LO && emit_cp <= SKIN_HI));
      last_nxt      = q_rdata.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_total_r  <= '0;
      partial_r    <= '0;
      broken_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        bytes_left_r <= bytes_left_nxt;
        seq_total_r  <= seq_total_nxt;
        partial_r    <= partial_nxt;
        broken_r     <= broken_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    len_r  <= len_nxt;
    ok_r   <= ok_nxt;
    mod_r  <= mod_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_seq_length  = len_r;
  assign out_valid_res   = ok_r;
  assign out_is_modifier = mod_r;
  assign out_last        = last_r;

  a_left_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != 2'd0) |-> ({1'b0, bytes_left_r} < seq_total_r))
    else $error("bytes left not below declared length");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (cp_r == '0 && !mod_r))
    else $error("invalid result carries a code point");

  a_open_seq_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && q_rdata.eos) |=> (bytes_left_r == 2'd0 && out_valid_r && last_r))
    else $error("string end left a sequence open");

endmodule

[hw/rtl/utf8_stream_decoder_top.sv]
// Top level of the UTF-8 stream decoder: front end, byte queue and sequence engine.
//
//  Channel   Direction  tdata (low bit up)                    tuser / tlast
//  in_*      slave      data_byte[7:0]                        tlast = end_of_string
//  out_*     master     code_point[20:0], seq_length[23:21]   tuser = valid_res, is_modifier;
//                                                             tlast = last_of_string
//
// One byte is accepted per clock while the byte queue is not full; a result passes the queue and the result register.
// The sequence engine advances one byte per cycle while a byte is queued and the result register is free or drained.
// The byte queue (FIFO_DEPTH entries) lets input keep flowing while a result waits at the output.
// Reset is synchronous, active low, and clears the queue, the sequence state and out_tvalid.
module utf8_stream_decoder_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] seq_length
  output logic [1:0]  out_tuser,  // [0] valid_res, [1] is_modifier
  output logic        out_tlast
);
  import u8sd_pkg::*;

  logic             q_full, q_push, q_pop, q_not_empty;
  cls_t             q_wdata, q_rdata;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             valid_res, is_modifier;

  u8sd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  u8sd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  u8sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_code_point  (code_point),
    .out_seq_length  (seq_length),
    .out_valid_res   (valid_res),
    .out_is_modifier (is_modifier),
    .out_last        (out_tlast)
  );

  assign out_tdata = {seq_length, code_point};
  assign out_tuser = {is_modifier, valid_res};

endmodule
